@@ rtl/rpj_pkg.sv @@
// shared types, constants and the quotient saturation function for the reprojection block
// no dependencies
`timescale 1ns / 1ps

package rpj_pkg;

   localparam int DATA_W  = 32;   // register and coordinate width
   localparam int PROD_W  = 41;   // disparity times gain, signed
   localparam int WGT_W   = 42;   // homogeneous weight, signed
   localparam int DEN_W   = 41;   // weight magnitude
   localparam int QUO_W   = 33;   // quotient bits kept before saturation

   localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

   localparam logic signed [DATA_W-1:0] OFFSET_X_RST   = -32'sd20971520;
   localparam logic signed [DATA_W-1:0] OFFSET_Y_RST   = -32'sd15728640;
   localparam logic signed [DATA_W-1:0] FOCAL_RST      = 32'sd32768000;
   localparam logic signed [DATA_W-1:0] GAIN_RST       = 32'sd655360;
   localparam logic signed [DATA_W-1:0] BIAS_RST       = 32'sd0;

   typedef enum logic [2:0] {
      CSR_OFFSET_X   = 3'd0,
      CSR_OFFSET_Y   = 3'd1,
      CSR_FOCAL      = 3'd2,
      CSR_GAIN       = 3'd3,
      CSR_BIAS       = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [7:0]  disparity;
      logic [11:0] column;
      logic [11:0] row;
      logic [7:0]  blue;
      logic [7:0]  green;
      logic [7:0]  red;
   } req_type;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic [23:0]        packed_colour;
      logic               divide_fault;
   } rsp_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] offset_x;
      logic signed [DATA_W-1:0] offset_y;
      logic signed [DATA_W-1:0] focal_length;
      logic signed [DATA_W-1:0] disparity_gain;
      logic signed [DATA_W-1:0] weight_bias;
   } cfg_type;

   typedef struct packed {
      logic num_neg;
      logic num_zero;
      logic den_neg;
      logic den_zero;
   } div_side_type;

   // returns {fault, value}
   function automatic logic [DATA_W:0] sat_quo(input logic [QUO_W-1:0] quo,
                                               input logic ovf,
                                               input div_side_type side);
      logic                neg;
      logic                over;
      logic [DATA_W-1:0]   val;
      logic                fault;
      neg   = side.num_neg ^ side.den_neg;
      over  = ovf;
      val   = '0;
      fault = 1'b0;
      if (side.den_zero) begin
         fault = 1'b1;
         if (side.num_zero) begin
            val = '0;
         end else if (side.num_neg) begin
            val = SAT_MIN;
         end else begin
            val = SAT_MAX;
         end
      end else begin
         if (neg) begin
            if (quo > {1'b0, SAT_MIN}) over = 1'b1;
         end else begin
            if (quo > {1'b0, SAT_MAX}) over = 1'b1;
         end
         if (over) begin
            fault = 1'b1;
            val   = neg ? SAT_MIN : SAT_MAX;
         end else begin
            val = neg ? (DATA_W'(0) - quo[DATA_W-1:0]) : quo[DATA_W-1:0];
         end
      end
      return {fault, val};
   endfunction

endpackage

@@ rtl/rpj_front.sv @@
// front end: weight multiply, numerator forming, magnitudes and signs (three stages)
// depends on rpj_pkg
`timescale 1ns / 1ps

module rpj_front import rpj_pkg::*; #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 16,
   parameter int NUM_W      = 33
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  req_type              in_data,
   input  cfg_type              cfg,
   output logic                 out_valid,
   output logic [23:0]          out_colour,
   output logic [NUM_W-1:0]     x_mag,
   output logic [NUM_W-1:0]     y_mag,
   output logic [NUM_W-1:0]     z_mag,
   output logic [DEN_W-1:0]     w_mag,
   output div_side_type         x_side,
   output div_side_type         y_side,
   output div_side_type         z_side
);

   logic [15:0]              col16;
   logic [15:0]              row16;
   logic [COORD_BITS-1:0]    col;
   logic [COORD_BITS-1:0]    row;

   // stage 1
   logic                     v1_ff, v1_in;
   logic signed [PROD_W-1:0] prod1_ff, prod1_in;
   logic signed [NUM_W-1:0]  nx1_ff, nx1_in, ny1_ff, ny1_in;
   logic signed [DATA_W-1:0] nz1_ff;
   logic [23:0]              c1_ff;
   // stage 2
   logic                     v2_ff;
   logic signed [WGT_W-1:0]  w2_ff, w2_in;
   logic signed [NUM_W-1:0]  nx2_ff, ny2_ff;
   logic signed [DATA_W-1:0] nz2_ff;
   logic [23:0]              c2_ff;
   // stage 3
   logic                     v3_ff;
   logic [NUM_W-1:0]         xm3_ff, ym3_ff, zm3_ff;
   logic [DEN_W-1:0]         wm3_ff;
   div_side_type             xs3_ff, ys3_ff, zs3_ff, xs3_in, ys3_in, zs3_in;
   logic [23:0]              c3_ff;
   logic signed [NUM_W-1:0]  nz2_ext;
   logic [WGT_W-1:0]         w2_abs;

   always_comb begin
      col16    = 16'(in_data.column);
      row16    = 16'(in_data.row);
      col      = col16[COORD_BITS-1:0];
      row      = row16[COORD_BITS-1:0];
      // zero disparity drops the beat here
      v1_in    = in_valid && (in_data.disparity != '0);
      prod1_in = PROD_W'(signed'({1'b0, in_data.disparity})) * PROD_W'(cfg.disparity_gain);
      nx1_in   = signed'(NUM_W'(col) << FRAC_BITS) + NUM_W'(cfg.offset_x);
      ny1_in   = signed'(NUM_W'(row) << FRAC_BITS) + NUM_W'(cfg.offset_y);
      w2_in    = WGT_W'(cfg.weight_bias) - WGT_W'(prod1_ff);
   end

   always_comb begin
      nz2_ext = NUM_W'(nz2_ff);
      w2_abs  = w2_ff[WGT_W-1] ? (WGT_W'(0) - w2_ff) : w2_ff;
      xs3_in  = '{num_neg: nx2_ff[NUM_W-1], num_zero: (nx2_ff == '0),
                  den_neg: w2_ff[WGT_W-1], den_zero: (w2_ff == '0)};
      ys3_in  = '{num_neg: ny2_ff[NUM_W-1], num_zero: (ny2_ff == '0),
                  den_neg: w2_ff[WGT_W-1], den_zero: (w2_ff == '0)};
      zs3_in  = '{num_neg: nz2_ff[DATA_W-1], num_zero: (nz2_ff == '0),
                  den_neg: w2_ff[WGT_W-1], den_zero: (w2_ff == '0)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= v1_in;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod1_ff <= prod1_in;
         nx1_ff   <= nx1_in;
         ny1_ff   <= ny1_in;
         nz1_ff   <= cfg.focal_length;
         c1_ff    <= {in_data.red, in_data.green, in_data.blue};

         w2_ff    <= w2_in;
         nx2_ff   <= nx1_ff;
         ny2_ff   <= ny1_ff;
         nz2_ff   <= nz1_ff;
         c2_ff    <= c1_ff;

         xm3_ff   <= nx2_ff[NUM_W-1] ? (NUM_W'(0) - nx2_ff) : nx2_ff;
         ym3_ff   <= ny2_ff[NUM_W-1] ? (NUM_W'(0) - ny2_ff) : ny2_ff;
         zm3_ff   <= nz2_ff[DATA_W-1] ? (NUM_W'(0) - nz2_ext) : nz2_ext;
         wm3_ff   <= w2_abs[DEN_W-1:0];
         xs3_ff   <= xs3_in;
         ys3_ff   <= ys3_in;
         zs3_ff   <= zs3_in;
         c3_ff    <= c2_ff;
      end
   end

   assign out_valid  = v3_ff;
   assign out_colour = c3_ff;
   assign x_mag      = xm3_ff;
   assign y_mag      = ym3_ff;
   assign z_mag      = zm3_ff;
   assign w_mag      = wm3_ff;
   assign x_side     = xs3_ff;
   assign y_side     = ys3_ff;
   assign z_side     = zs3_ff;

endmodule

@@ rtl/rpj_div.sv @@
// pipelined restoring divider, one quotient bit per stage, with overflow flag
// depends on rpj_pkg
`timescale 1ns / 1ps

module rpj_div import rpj_pkg::*; #(
   parameter int NUM_W     = 33,
   parameter int FRAC_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [NUM_W-1:0]    num,
   input  logic [DEN_W-1:0]    den,
   input  div_side_type        in_side,
   output logic                out_valid,
   output logic [QUO_W-1:0]    quo,
   output logic                ovf,
   output div_side_type        out_side
);

   localparam int TW = NUM_W + FRAC_BITS;
   localparam int IW = TW - QUO_W;
   localparam int CW = (IW > DEN_W) ? IW : DEN_W;
   localparam int RW = DEN_W + 1;

   logic [TW-1:0]      dividend;
   logic [IW-1:0]      init;
   logic               ovf0;

   logic               valid_ff [0:QUO_W];
   logic [DEN_W-1:0]   rem_ff   [0:QUO_W];
   logic [DEN_W-1:0]   den_ff   [0:QUO_W];
   logic [QUO_W-1:0]   low_ff   [0:QUO_W];
   logic [QUO_W-1:0]   quo_ff   [0:QUO_W];
   logic               ovf_ff   [0:QUO_W];
   div_side_type       side_ff  [0:QUO_W];

   logic [RW-1:0]      trial    [1:QUO_W];
   logic [RW-1:0]      diff     [1:QUO_W];

   always_comb begin
      dividend = {num, FRAC_BITS'(0)};
      init     = dividend[TW-1:QUO_W];
      // quotient would need more than QUO_W bits
      ovf0     = CW'(init) >= CW'(den);
   end

   always_comb begin
      for (int j = 1; j <= QUO_W; j++) begin
         trial[j] = {rem_ff[j-1], low_ff[j-1][QUO_W-1]};
         diff[j]  = trial[j] - {1'b0, den_ff[j-1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= QUO_W; j++) valid_ff[j] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
         for (int j = 1; j <= QUO_W; j++) valid_ff[j] <= valid_ff[j-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= DEN_W'(init);
         den_ff[0]  <= den;
         low_ff[0]  <= dividend[QUO_W-1:0];
         quo_ff[0]  <= '0;
         ovf_ff[0]  <= ovf0;
         side_ff[0] <= in_side;
         for (int j = 1; j <= QUO_W; j++) begin
            if (!diff[j][RW-1]) begin
               rem_ff[j] <= diff[j][DEN_W-1:0];
               quo_ff[j] <= {quo_ff[j-1][QUO_W-2:0], 1'b1};
            end else begin
               rem_ff[j] <= trial[j][DEN_W-1:0];
               quo_ff[j] <= {quo_ff[j-1][QUO_W-2:0], 1'b0};
            end
            den_ff[j]  <= den_ff[j-1];
            low_ff[j]  <= {low_ff[j-1][QUO_W-2:0], 1'b0};
            ovf_ff[j]  <= ovf_ff[j-1];
            side_ff[j] <= side_ff[j-1];
         end
      end
   end

   assign out_valid = valid_ff[QUO_W];
   assign quo       = quo_ff[QUO_W];
   assign ovf       = ovf_ff[QUO_W];
   assign out_side  = side_ff[QUO_W];

endmodule

@@ rtl/disparity_to_point_reprojection_top.sv @@
// top level: config registers, front end, three dividers, colour delay, output register
// depends on rpj_pkg, rpj_front, rpj_div
`timescale 1ns / 1ps
//
//  channel   direction  handshake               payload
//  req       in         req_valid / req_ready   req_data (req_type)
//  rsp       out        rsp_valid / rsp_ready   rsp_data (rsp_type)
//  csr       in         csr_valid / csr_ready   csr_index, csr_data
//
//  one pixel per clock while the output is not stalled; 38 register stages: three front
//  stages, the 34-stage divider (a load stage, then one quotient bit per stage) and the
//  output register.
//  the whole pipeline advances when the output register is empty or taken,
//  so a stall holds every stage in place. zero-disparity beats are dropped.
//  reset clears the valid bits and loads the default reprojection values.

module disparity_to_point_reprojection_top import rpj_pkg::*; #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  req_type       req_data,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_type       rsp_data,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [2:0]    csr_index,
   input  logic [31:0]   csr_data
);

   localparam int NUM_W = ((COORD_BITS + FRAC_BITS > 31) ? COORD_BITS + FRAC_BITS : 31) + 2;
   localparam int DLY   = QUO_W + 1;

   logic               en;
   cfg_type            cfg_ff;
   logic               f_valid;
   logic [23:0]        f_colour;
   logic [NUM_W-1:0]   x_mag, y_mag, z_mag;
   logic [DEN_W-1:0]   w_mag;
   div_side_type       x_side, y_side, z_side;
   div_side_type       xo_side, yo_side, zo_side;
   logic               x_valid, y_valid, z_valid;
   logic [QUO_W-1:0]   x_quo, y_quo, z_quo;
   logic               x_ovf, y_ovf, z_ovf;
   logic [23:0]        colour_ff [0:DLY-1];
   logic [DATA_W:0]    x_res, y_res, z_res;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff, rsp_in;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.offset_x       <= OFFSET_X_RST;
         cfg_ff.offset_y       <= OFFSET_Y_RST;
         cfg_ff.focal_length   <= FOCAL_RST;
         cfg_ff.disparity_gain <= GAIN_RST;
         cfg_ff.weight_bias    <= BIAS_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_OFFSET_X: cfg_ff.offset_x       <= csr_data;
            CSR_OFFSET_Y: cfg_ff.offset_y       <= csr_data;
            CSR_FOCAL:    cfg_ff.focal_length   <= csr_data;
            CSR_GAIN:     cfg_ff.disparity_gain <= csr_data;
            CSR_BIAS:     cfg_ff.weight_bias    <= csr_data;
            default: ;
         endcase
      end
   end

   rpj_front #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS),
      .NUM_W      (NUM_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (req_valid),
      .in_data    (req_data),
      .cfg        (cfg_ff),
      .out_valid  (f_valid),
      .out_colour (f_colour),
      .x_mag      (x_mag),
      .y_mag      (y_mag),
      .z_mag      (z_mag),
      .w_mag      (w_mag),
      .x_side     (x_side),
      .y_side     (y_side),
      .z_side     (z_side)
   );

   rpj_div #(.NUM_W(NUM_W), .FRAC_BITS(FRAC_BITS)) u_div_x (
      .clock (clock), .reset (reset), .en (en), .in_valid (f_valid),
      .num (x_mag), .den (w_mag), .in_side (x_side),
      .out_valid (x_valid), .quo (x_quo), .ovf (x_ovf), .out_side (xo_side)
   );

   rpj_div #(.NUM_W(NUM_W), .FRAC_BITS(FRAC_BITS)) u_div_y (
      .clock (clock), .reset (reset), .en (en), .in_valid (f_valid),
      .num (y_mag), .den (w_mag), .in_side (y_side),
      .out_valid (y_valid), .quo (y_quo), .ovf (y_ovf), .out_side (yo_side)
   );

   rpj_div #(.NUM_W(NUM_W), .FRAC_BITS(FRAC_BITS)) u_div_z (
      .clock (clock), .reset (reset), .en (en), .in_valid (f_valid),
      .num (z_mag), .den (w_mag), .in_side (z_side),
      .out_valid (z_valid), .quo (z_quo), .ovf (z_ovf), .out_side (zo_side)
   );

   // colour rides alongside the divider stages
   always_ff @(posedge clock) begin
      if (en) begin
         colour_ff[0] <= f_colour;
         for (int j = 1; j < DLY; j++) colour_ff[j] <= colour_ff[j-1];
      end
   end

   always_comb begin
      x_res = sat_quo(x_quo, x_ovf, xo_side);
      y_res = sat_quo(y_quo, y_ovf, yo_side);
      z_res = sat_quo(z_quo, z_ovf, zo_side);
      rsp_in.point_x       = x_res[DATA_W-1:0];
      rsp_in.point_y       = y_res[DATA_W-1:0];
      rsp_in.point_z       = z_res[DATA_W-1:0];
      rsp_in.packed_colour = colour_ff[DLY-1];
      rsp_in.divide_fault  = x_res[DATA_W] | y_res[DATA_W] | z_res[DATA_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= x_valid & y_valid & z_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
